// ===== hdl/cmtm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmtm_pkg
// Shared types and codes of the multilevel cache tag model.
// ----------------------------------------------------------------------------
package cmtm_pkg;

    // sequencer states
    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_PROBE_RD = 10'b0000000100,
        ST_PROBE_CK = 10'b0000001000,
        ST_FILL_RD  = 10'b0000010000,
        ST_VICT     = 10'b0000100000,
        ST_FILL_CK  = 10'b0001000000,
        ST_PAR_RD   = 10'b0010000000,
        ST_PAR_CK   = 10'b0100000000,
        ST_DONE     = 10'b1000000000
    } t_state;

    // rewrite controls for the shared set unit
    typedef struct packed {
        logic replace;
        logic mark;
        logic front;
    } t_set_ctl;

    // configuration register indexes
    localparam logic [2:0] CFG_LEVEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_WRITE_BACK  = 3'd1;
    localparam logic [2:0] CFG_POLICY      = 3'd2;
    localparam logic [2:0] CFG_OFFSET      = 3'd3;
    localparam logic [2:0] CFG_SET_FIRST   = 3'd4;
    localparam logic [2:0] CFG_SET_SECOND  = 3'd5;
    localparam logic [2:0] CFG_SET_THIRD   = 3'd6;

    // replacement policies
    localparam logic [1:0] POL_LRU    = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    // level codes
    localparam logic [1:0] LVL_FIRST  = 2'd0;
    localparam logic [1:0] LVL_SECOND = 2'd1;
    localparam logic [1:0] LVL_THIRD  = 2'd2;
    localparam logic [1:0] LVL_NONE   = 2'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam int OFFSET_MAX = 15;
    localparam int CFG_W      = 4;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

endpackage

// ===== hdl/multilevel_cache_tag_model_unit.sv =====
// ----------------------------------------------------------------------------
// multilevel_cache_tag_model_unit
// Three-level set-associative cache tag model with LRU, FIFO, random or
// way-zero replacement and write-through or write-back handling.
// ----------------------------------------------------------------------------
// One access is handled at a time by a sequencer that walks the levels with a
// single shared set unit. Each probe, fill or parent dirty mark is a row read
// then a compare and rewrite; a random victim first takes the remainder of the
// LFSR value by the way count in ST_VICT, and the result is set in ST_DONE.
// A result still waiting at the output holds the sequencer in its result state.
// After reset the tag stores are cleared one set a cycle over all
// 2**MAX_SET_BITS sets, and no access is taken meanwhile; configuration
// writes are taken at any time.
module multilevel_cache_tag_model_unit #(
    parameter int ADDR_BITS    = 32,
    parameter int MAX_SET_BITS = 10,
    parameter int WAYS_FIRST   = 4,
    parameter int WAYS_SECOND  = 8,
    parameter int WAYS_THIRD   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_idx,
    input  logic [cmtm_pkg::CFG_W-1:0]         i_cfg_data,
    // access words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [cmtm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // address
    input  logic                               s_axis_tuser,  // opcode
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hit_level, memory_fetch, memory_writes, accesses_first,
    // accesses_second, accesses_third, zero fill
    output logic [cmtm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import cmtm_pkg::*;

    localparam int LINE_W  = ADDR_BITS + 2;
    localparam int MAXW12  = (WAYS_FIRST > WAYS_SECOND) ? WAYS_FIRST : WAYS_SECOND;
    localparam int MAXW    = (MAXW12 > WAYS_THIRD) ? MAXW12 : WAYS_THIRD;
    localparam int WIDX    = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int WAY_W   = $clog2(MAXW + 1);
    localparam int VA_W    = ADDR_BITS + OFFSET_MAX + MAX_SET_BITS;
    localparam int SH_W    = $clog2(OFFSET_MAX + MAX_SET_BITS + 1);
    localparam int ROW_W   = MAXW * LINE_W;

    // configuration registers
    logic [1:0]       r_level_count;
    logic             r_write_back;
    logic [1:0]       r_policy;
    logic [CFG_W-1:0] r_offset;
    logic [CFG_W-1:0] r_sb_first;
    logic [CFG_W-1:0] r_sb_second;
    logic [CFG_W-1:0] r_sb_third;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= 2'd3;
            r_write_back  <= 1'b0;
            r_policy      <= POL_LRU;
            r_offset      <= CFG_W'(6);
            r_sb_first    <= CFG_W'(6);
            r_sb_second   <= CFG_W'(8);
            r_sb_third    <= CFG_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[1:0];
                CFG_WRITE_BACK:  r_write_back  <= i_cfg_data[0];
                CFG_POLICY:      r_policy      <= i_cfg_data[1:0];
                CFG_OFFSET:      r_offset      <= i_cfg_data;
                CFG_SET_FIRST:   r_sb_first    <= i_cfg_data;
                CFG_SET_SECOND:  r_sb_second   <= i_cfg_data;
                CFG_SET_THIRD:   r_sb_third    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer registers
    t_state                r_state, n_state;
    logic [1:0]            r_lv, n_lv;
    logic [1:0]            r_fill, n_fill;
    logic [1:0]            r_hit, n_hit;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic                  r_store, n_store;
    logic [VA_W-1:0]       r_vaddr, n_vaddr;
    logic [MAX_SET_BITS-1:0] r_idx, n_idx;
    logic [MAX_SET_BITS-1:0] r_clr, n_clr;
    logic [1:0]            r_acc1, n_acc1;
    logic [2:0]            r_acc2, n_acc2;
    logic [2:0]            r_acc3, n_acc3;
    logic [1:0]            r_mw, n_mw;
    logic [15:0]           r_lfsr, n_lfsr;
    logic [4:0]            r_rem, n_rem;
    logic                  r_vstep, n_vstep;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // level view for the active level
    logic [1:0]            nlev;
    logic [CFG_W-1:0]      sb_raw, sb;
    logic [SH_W-1:0]       shamt;
    logic [VA_W-1:0]       key;
    logic [VA_W-1:0]       key_off;
    logic [MAX_SET_BITS-1:0] idx_c;
    logic [VA_W-1:0]       tag_c;
    logic [WAY_W-1:0]      ways_sel;
    logic [ROW_W-1:0]      row_sel;
    logic [2:0]            rd_en, wr_en;
    logic                  clearing;
    logic                  pol_order;
    logic                  store_mark;

    // shared set unit
    logic [WIDX-1:0]       u_way;
    t_set_ctl              u_ctl;
    logic                  u_hit;
    logic [WIDX-1:0]       u_hit_way;
    logic [LINE_W-1:0]     u_way_line;
    logic [ROW_W-1:0]      u_row;
    logic [VA_W-1:0]       vaddr_c;
    logic [4:0]            rem_c;
    logic [5:0]            rem_t;

    logic [WAYS_FIRST*LINE_W-1:0]  row1;
    logic [WAYS_SECOND*LINE_W-1:0] row2;
    logic [WAYS_THIRD*LINE_W-1:0]  row3;

    assign nlev      = (r_level_count == 2'd0) ? 2'd1 : r_level_count;
    assign pol_order = (r_policy == POL_LRU) || (r_policy == POL_FIFO);
    assign store_mark = (r_lv == LVL_FIRST) && r_store && r_write_back;

    // level select
    always_comb begin
        case (r_lv)
            LVL_FIRST: begin
                sb_raw   = r_sb_first;
                ways_sel = WAY_W'(WAYS_FIRST);
                row_sel  = ROW_W'(row1);
            end
            LVL_SECOND: begin
                sb_raw   = r_sb_second;
                ways_sel = WAY_W'(WAYS_SECOND);
                row_sel  = ROW_W'(row2);
            end
            default: begin
                sb_raw   = r_sb_third;
                ways_sel = WAY_W'(WAYS_THIRD);
                row_sel  = ROW_W'(row3);
            end
        endcase
    end

    // address split for the active level
    assign sb      = (sb_raw > CFG_W'(MAX_SET_BITS)) ? CFG_W'(MAX_SET_BITS) : sb_raw;
    assign shamt   = SH_W'(r_offset) + SH_W'(sb);
    assign key     = ((r_state == ST_PAR_RD) || (r_state == ST_PAR_CK)) ? r_vaddr
                     : VA_W'(r_addr);
    assign key_off = key >> r_offset;
    assign idx_c   = key_off[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sb);
    assign tag_c   = key >> shamt;

    // victim address rebuilt from the victim's own tag
    assign vaddr_c = (VA_W'(u_way_line[ADDR_BITS-1:0]) << shamt)
                     | (VA_W'(r_idx) << r_offset);

    // remainder of the LFSR value by the way count, eight bits a cycle
    always_comb begin
        rem_c = r_rem;
        for (int k = 7; k >= 0; k--) begin
            rem_t = {rem_c, (r_vstep ? r_lfsr[k] : r_lfsr[k+8])};
            if (rem_t >= 6'(ways_sel)) begin
                rem_t = rem_t - 6'(ways_sel);
            end
            rem_c = rem_t[4:0];
        end
    end

    // set unit controls
    always_comb begin
        u_way = u_hit_way;
        u_ctl = '0;
        case (r_state)
            ST_PROBE_CK: begin
                u_ctl.front = (r_policy == POL_LRU);
                u_ctl.mark  = store_mark;
            end
            ST_FILL_CK: begin
                if (pol_order) begin
                    u_way = WIDX'(ways_sel - WAY_W'(1));
                end else if (r_policy == POL_RANDOM) begin
                    u_way = WIDX'(r_rem);
                end else begin
                    u_way = '0;
                end
                u_ctl.replace = 1'b1;
                u_ctl.front   = pol_order;
                u_ctl.mark    = store_mark;
            end
            ST_PAR_CK: begin
                u_ctl.mark = 1'b1;
            end
            default: ;
        endcase
    end

    cmtm_set_unit #(
        .ADDR_BITS (ADDR_BITS),
        .VA_W      (VA_W),
        .MAXW      (MAXW)
    ) u_set (
        .i_row      (row_sel),
        .i_ways     (ways_sel),
        .i_tag      (tag_c),
        .i_way      (u_way),
        .i_line     ({2'b01, tag_c[ADDR_BITS-1:0]}),
        .i_ctl      (u_ctl),
        .o_hit      (u_hit),
        .o_hit_way  (u_hit_way),
        .o_way_line (u_way_line),
        .o_row      (u_row)
    );

    // tag stores
    assign clearing = (r_state == ST_CLEAR);

    always_comb begin
        rd_en = 3'b000;
        wr_en = 3'b000;
        if ((r_state == ST_PROBE_RD) || (r_state == ST_FILL_RD) || (r_state == ST_PAR_RD)) begin
            rd_en[r_lv] = 1'b1;
        end
        if (clearing) begin
            wr_en = 3'b111;
        end else if (((r_state == ST_PROBE_CK) || (r_state == ST_PAR_CK)) && u_hit) begin
            wr_en[r_lv] = 1'b1;
        end else if (r_state == ST_FILL_CK) begin
            wr_en[r_lv] = 1'b1;
        end
    end

    cmtm_tag_store #(
        .WAYS (WAYS_FIRST), .LINE_W (LINE_W), .SET_BITS (MAX_SET_BITS)
    ) u_store_first (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en[0]),
        .i_rd_idx (idx_c),
        .o_rd_row (row1),
        .i_wr_en  (wr_en[0]),
        .i_wr_idx (clearing ? r_clr : r_idx),
        .i_wr_row (clearing ? '0 : u_row[WAYS_FIRST*LINE_W-1:0])
    );

    cmtm_tag_store #(
        .WAYS (WAYS_SECOND), .LINE_W (LINE_W), .SET_BITS (MAX_SET_BITS)
    ) u_store_second (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en[1]),
        .i_rd_idx (idx_c),
        .o_rd_row (row2),
        .i_wr_en  (wr_en[1]),
        .i_wr_idx (clearing ? r_clr : r_idx),
        .i_wr_row (clearing ? '0 : u_row[WAYS_SECOND*LINE_W-1:0])
    );

    cmtm_tag_store #(
        .WAYS (WAYS_THIRD), .LINE_W (LINE_W), .SET_BITS (MAX_SET_BITS)
    ) u_store_third (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en[2]),
        .i_rd_idx (idx_c),
        .o_rd_row (row3),
        .i_wr_en  (wr_en[2]),
        .i_wr_idx (clearing ? r_clr : r_idx),
        .i_wr_row (clearing ? '0 : u_row[WAYS_THIRD*LINE_W-1:0])
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // sequencer
    always_comb begin
        logic       wt_store;
        logic [2:0] fin_acc2, fin_acc3;
        logic [1:0] fin_mw;

        n_state     = r_state;
        n_lv        = r_lv;
        n_fill      = r_fill;
        n_hit       = r_hit;
        n_addr      = r_addr;
        n_store     = r_store;
        n_vaddr     = r_vaddr;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_acc1      = r_acc1;
        n_acc2      = r_acc2;
        n_acc3      = r_acc3;
        n_mw        = r_mw;
        n_lfsr      = r_lfsr;
        n_rem       = r_rem;
        n_vstep     = r_vstep;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        wt_store    = r_store && !r_write_back;
        fin_mw      = r_mw + {1'b0, wt_store};
        fin_acc2    = r_acc2 + {2'b00, (wt_store && (nlev > 2'd1))};
        fin_acc3    = r_acc3 + {2'b00, (wt_store && (nlev > 2'd2))};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // one access counted in the active level
        if ((r_state == ST_PROBE_CK) || (r_state == ST_FILL_CK) || (r_state == ST_PAR_CK)) begin
            case (r_lv)
                LVL_FIRST:  n_acc1 = r_acc1 + 2'd1;
                LVL_SECOND: n_acc2 = r_acc2 + 3'd1;
                default:    n_acc3 = r_acc3 + 3'd1;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + MAX_SET_BITS'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_addr  = s_axis_tdata[ADDR_BITS-1:0];
                    n_store = s_axis_tuser;
                    n_lv    = LVL_FIRST;
                    n_hit   = LVL_NONE;
                    n_acc1  = '0;
                    n_acc2  = '0;
                    n_acc3  = '0;
                    n_mw    = '0;
                    n_state = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                n_idx   = idx_c;
                n_state = ST_PROBE_CK;
            end
            ST_PROBE_CK: begin
                if (u_hit) begin
                    n_hit = r_lv;
                    if (r_lv == LVL_FIRST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_lv    = r_lv - 2'd1;
                        n_fill  = r_lv - 2'd1;
                        n_state = ST_FILL_RD;
                    end
                end else if ((r_lv + 2'd1) < nlev) begin
                    n_lv    = r_lv + 2'd1;
                    n_state = ST_PROBE_RD;
                end else begin
                    n_fill  = r_lv;
                    n_state = ST_FILL_RD;
                end
            end
            ST_FILL_RD: begin
                n_idx = idx_c;
                if (r_policy == POL_RANDOM) begin
                    n_lfsr  = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};
                    n_rem   = '0;
                    n_vstep = 1'b0;
                    n_state = ST_VICT;
                end else begin
                    n_state = ST_FILL_CK;
                end
            end
            ST_VICT: begin
                n_rem   = rem_c;
                n_vstep = 1'b1;
                if (r_vstep) begin
                    n_state = ST_FILL_CK;
                end
            end
            ST_FILL_CK: begin
                if (r_write_back && u_way_line[ADDR_BITS] && u_way_line[ADDR_BITS+1]
                    && ((r_lv + 2'd1) < nlev)) begin
                    n_vaddr = vaddr_c;
                    n_lv    = r_lv + 2'd1;
                    n_state = ST_PAR_RD;
                end else begin
                    if (r_write_back && u_way_line[ADDR_BITS] && u_way_line[ADDR_BITS+1]) begin
                        n_mw = r_mw + 2'd1;
                    end
                    if (r_fill == LVL_FIRST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_fill  = r_fill - 2'd1;
                        n_lv    = r_fill - 2'd1;
                        n_state = ST_FILL_RD;
                    end
                end
            end
            ST_PAR_RD: begin
                n_idx   = idx_c;
                n_state = ST_PAR_CK;
            end
            ST_PAR_CK: begin
                if (r_fill == LVL_FIRST) begin
                    n_state = ST_DONE;
                end else begin
                    n_fill  = r_fill - 2'd1;
                    n_lv    = r_fill - 2'd1;
                    n_state = ST_FILL_RD;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, fin_acc3, fin_acc2, r_acc1, fin_mw,
                                   (r_hit == LVL_NONE), r_hit};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
            r_lv        <= LVL_FIRST;
            r_fill      <= LVL_FIRST;
            r_vstep     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_lfsr      <= n_lfsr;
            r_out_valid <= n_out_valid;
            r_lv        <= n_lv;
            r_fill      <= n_fill;
            r_vstep     <= n_vstep;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_addr     <= n_addr;
        r_store    <= n_store;
        r_vaddr    <= n_vaddr;
        r_idx      <= n_idx;
        r_acc1     <= n_acc1;
        r_acc2     <= n_acc2;
        r_acc3     <= n_acc3;
        r_mw       <= n_mw;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

    // level one is probed on every access
    a_first_probed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:5] != 2'b00))
        else $error("result without a level one access");

    // a memory fetch goes with a full miss
    a_fetch_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] == LVL_NONE)))
        else $error("memory fetch does not match hit level");

    // outside the clearing pass at most one store is written a cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clearing |-> ($countones(wr_en) <= 1))
        else $error("several tag stores written at once");

    // a held result is not replaced before it is taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

// ===== hdl/cmtm_tag_store.sv =====
// ----------------------------------------------------------------------------
// cmtm_tag_store
// Tag store of one level: one row per set holding every way's line.
// ----------------------------------------------------------------------------
module cmtm_tag_store #(
    parameter int WAYS      = 4,
    parameter int LINE_W    = 34,
    parameter int SET_BITS  = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [SET_BITS-1:0]      i_rd_idx,
    output logic [WAYS*LINE_W-1:0]   o_rd_row,
    input  logic                     i_wr_en,
    input  logic [SET_BITS-1:0]      i_wr_idx,
    input  logic [WAYS*LINE_W-1:0]   i_wr_row
);

    logic [WAYS*LINE_W-1:0] r_mem [2**SET_BITS];
    logic [WAYS*LINE_W-1:0] r_rd_row;

    // row write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_row;
        end
    end

    // registered row read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ===== hdl/cmtm_set_unit.sv =====
// ----------------------------------------------------------------------------
// cmtm_set_unit
// Shared set unit: tag match over one row and rewrite of that row.
// ----------------------------------------------------------------------------
module cmtm_set_unit #(
    parameter int ADDR_BITS = 32,
    parameter int VA_W      = 57,
    parameter int MAXW      = 16
) (
    input  logic [MAXW*(ADDR_BITS+2)-1:0]       i_row,
    input  logic [$clog2(MAXW+1)-1:0]           i_ways,
    input  logic [VA_W-1:0]                     i_tag,
    input  logic [((MAXW>1)?$clog2(MAXW):1)-1:0] i_way,
    input  logic [ADDR_BITS+1:0]                i_line,
    input  cmtm_pkg::t_set_ctl                  i_ctl,
    output logic                                o_hit,
    output logic [((MAXW>1)?$clog2(MAXW):1)-1:0] o_hit_way,
    output logic [ADDR_BITS+1:0]                o_way_line,
    output logic [MAXW*(ADDR_BITS+2)-1:0]       o_row
);
    import cmtm_pkg::*;

    localparam int LINE_W = ADDR_BITS + 2;
    localparam int WIDX   = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int WAY_W  = $clog2(MAXW + 1);

    logic [LINE_W-1:0] line_mod;

    // first valid way whose tag matches
    always_comb begin
        o_hit     = 1'b0;
        o_hit_way = '0;
        for (int w = MAXW - 1; w >= 0; w--) begin
            if ((WAY_W'(w) < i_ways) && i_row[w*LINE_W + ADDR_BITS]
                && ({{(VA_W-ADDR_BITS){1'b0}}, i_row[w*LINE_W +: ADDR_BITS]} == i_tag)) begin
                o_hit     = 1'b1;
                o_hit_way = WIDX'(w);
            end
        end
    end

    // line at the chosen way and its new value
    assign o_way_line = i_row[i_way*LINE_W +: LINE_W];

    always_comb begin
        line_mod = i_ctl.replace ? i_line : o_way_line;
        if (i_ctl.mark) begin
            line_mod[LINE_W-1] = 1'b1;
        end
    end

    // row rewrite, with optional move to front
    always_comb begin
        o_row = i_row;
        for (int w = 0; w < MAXW; w++) begin
            if (i_ctl.front) begin
                if (w == 0) begin
                    o_row[w*LINE_W +: LINE_W] = line_mod;
                end else if (WIDX'(w) <= i_way) begin
                    o_row[w*LINE_W +: LINE_W] = i_row[(w-1)*LINE_W +: LINE_W];
                end
            end else if (WIDX'(w) == i_way) begin
                o_row[w*LINE_W +: LINE_W] = line_mod;
            end
        end
    end

endmodule

// ===== sim/tb_multilevel_cache_tag_model_unit.sv =====
// ----------------------------------------------------------------------------
// tb_multilevel_cache_tag_model_unit
// Self-checking bench for the multilevel cache tag model. Loads and stores are
// streamed in under several level, policy and geometry settings. A scoreboard
// keeps its own copy of the three tag stores and the victim LFSR, predicts
// every result word and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module tb_multilevel_cache_tag_model_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cmtm_pkg::*;

    localparam int SETS      = 1024;
    localparam int SET_MAX   = 10;
    localparam int WATCH_MAX = 6000;
    localparam int HOLD_LEN  = 300;

    typedef struct {
        logic [1:0] hit_level;
        logic       memory_fetch;
        logic [1:0] memory_writes;
        logic [1:0] acc_first;
        logic [2:0] acc_second;
        logic [2:0] acc_third;
    } t_outcome;

    // tag store copy, access prediction and result checking
    class access_scoreboard;
        longint unsigned line_tag[3][SETS][16];
        bit              line_valid[3][SETS][16];
        bit              line_dirty[3][SETS][16];
        logic [15:0]     lfsr;
        int unsigned     reg_val[7];
        t_outcome        waiting[$];
        int              mismatches;
        int              checked;
        int              hits[4];

        function new();
            lfsr = LFSR_SEED;
            reg_val = '{3, 0, 0, 6, 6, 8, 10};
            mismatches = 0;
            checked = 0;
            hits = '{0, 0, 0, 0};
        endfunction

        function void set_reg(int idx, int unsigned val);
            reg_val[idx] = val & ((idx == CFG_WRITE_BACK) ? 1 : (idx <= CFG_POLICY) ? 3 : 15);
        endfunction

        function int ways_of(int lv);
            return lv == 0 ? 4 : (lv == 1 ? 8 : 16);
        endfunction

        function int sbits(int lv);
            int s;
            s = reg_val[CFG_SET_FIRST + lv];
            return s > SET_MAX ? SET_MAX : s;
        endfunction

        function int set_idx(int lv, longint unsigned a);
            return int'((a >> reg_val[CFG_OFFSET]) & ((64'd1 << sbits(lv)) - 1));
        endfunction

        function longint unsigned tag_of(int lv, longint unsigned a);
            return a >> (reg_val[CFG_OFFSET] + sbits(lv));
        endfunction

        function int find_way(int lv, longint unsigned a);
            int s;
            s = set_idx(lv, a);
            for (int w = 0; w < ways_of(lv); w++)
                if (line_valid[lv][s][w] && line_tag[lv][s][w] == tag_of(lv, a)) return w;
            return -1;
        endfunction

        // move one way to the front, the ways in front of it shift back by one
        function void to_front(int lv, int s, int way);
            longint unsigned t;
            bit v, d;
            t = line_tag[lv][s][way];
            v = line_valid[lv][s][way];
            d = line_dirty[lv][s][way];
            for (int i = way; i > 0; i--) begin
                line_tag[lv][s][i]   = line_tag[lv][s][i-1];
                line_valid[lv][s][i] = line_valid[lv][s][i-1];
                line_dirty[lv][s][i] = line_dirty[lv][s][i-1];
            end
            line_tag[lv][s][0]   = t;
            line_valid[lv][s][0] = v;
            line_dirty[lv][s][0] = d;
        endfunction

        function void fill_line(int lv, int nlev, longint unsigned a,
                                ref int acc[3], ref int mw);
            int s, way, pw;
            longint unsigned vaddr;
            s = set_idx(lv, a);
            way = 0;
            acc[lv]++;
            if (reg_val[CFG_POLICY] == POL_LRU || reg_val[CFG_POLICY] == POL_FIFO)
                way = ways_of(lv) - 1;
            else if (reg_val[CFG_POLICY] == POL_RANDOM) begin
                lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                way = int'(lfsr) % ways_of(lv);
            end
            // dirty victim goes to the next level or out to memory
            if (reg_val[CFG_WRITE_BACK] != 0 && line_valid[lv][s][way] && line_dirty[lv][s][way])
            begin
                vaddr = (line_tag[lv][s][way] << (reg_val[CFG_OFFSET] + sbits(lv)))
                      | (longint'(s) << reg_val[CFG_OFFSET]);
                if (lv + 1 < nlev) begin
                    pw = find_way(lv + 1, vaddr);
                    acc[lv+1]++;
                    if (pw >= 0) line_dirty[lv+1][set_idx(lv + 1, vaddr)][pw] = 1;
                end else begin
                    mw++;
                end
            end
            line_tag[lv][s][way]   = tag_of(lv, a);
            line_valid[lv][s][way] = 1;
            line_dirty[lv][s][way] = 0;
            if (reg_val[CFG_POLICY] == POL_LRU || reg_val[CFG_POLICY] == POL_FIFO)
                to_front(lv, s, way);
        endfunction

        // work out the result word of one accepted access
        function void note_access(bit store, logic [31:0] addr);
            int acc[3];
            int mw, hit, nlev, last, w;
            t_outcome r;
            acc = '{0, 0, 0};
            mw = 0;
            hit = 3;
            nlev = reg_val[CFG_LEVEL_COUNT] == 0 ? 1 : reg_val[CFG_LEVEL_COUNT];
            for (int lv = 0; lv < nlev; lv++) begin
                w = find_way(lv, addr);
                acc[lv]++;
                if (w >= 0) begin
                    hit = lv;
                    if (reg_val[CFG_POLICY] == POL_LRU) to_front(lv, set_idx(lv, addr), w);
                    break;
                end
            end
            last = hit == 3 ? nlev - 1 : hit;
            for (int i = last; i >= 0; i--)
                if (i != hit) fill_line(i, nlev, addr, acc, mw);
            if (store) begin
                if (reg_val[CFG_WRITE_BACK] == 0) begin
                    mw++;
                    for (int lv = 1; lv < nlev; lv++) acc[lv]++;
                end else begin
                    w = find_way(0, addr);
                    if (w >= 0) line_dirty[0][set_idx(0, addr)][w] = 1;
                end
            end
            hits[hit]++;
            r.hit_level     = hit[1:0];
            r.memory_fetch  = hit == 3;
            r.memory_writes = mw[1:0];
            r.acc_first     = acc[0][1:0];
            r.acc_second    = acc[1][2:0];
            r.acc_third     = acc[2][2:0];
            waiting.push_back(r);
        endfunction

        function void report(string what, int e, int a);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on word %0d: %s expected %0d got %0d", checked, what, e, a);
        endfunction

        // compare one result word with the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_outcome e;
            checked++;
            if (waiting.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = waiting.pop_front();
            if (d[1:0] !== e.hit_level)     report("hit_level", e.hit_level, d[1:0]);
            if (d[2] !== e.memory_fetch)    report("memory_fetch", e.memory_fetch, d[2]);
            if (d[4:3] !== e.memory_writes) report("memory_writes", e.memory_writes, d[4:3]);
            if (d[6:5] !== e.acc_first)     report("accesses_first", e.acc_first, d[6:5]);
            if (d[9:7] !== e.acc_second)    report("accesses_second", e.acc_second, d[9:7]);
            if (d[12:10] !== e.acc_third)   report("accesses_third", e.acc_third, d[12:10]);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [2:0]             i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // address
    logic                   s_axis_tuser;   // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // hit_level, memory_fetch, memory_writes, accesses_first,
    // accesses_second, accesses_third, zero fill
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    multilevel_cache_tag_model_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    access_scoreboard sb = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_go = 0;
    bit          hold_on = 0;
    int          quiet_cycles = 0;
    int          sent = 0;
    logic [31:0] addr_pool[24];

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver readiness, random stalls and the long hold-off
    always @(negedge i_clk) begin
        m_axis_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            wait (hold_go);
            hold_on = 1;
            repeat (HOLD_LEN) @(posedge i_clk);
            hold_on = 0;
            hold_go = 0;
        end
    end

    // result words and watchdog
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX) begin
            $display("watchdog expired with %0d words outstanding", sb.waiting.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_access(bit store, logic [31:0] addr);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        s_axis_tuser  <= store;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_access(store, addr);
        sent++;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.waiting.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic configure(int unsigned lv, int unsigned wb, int unsigned pol,
                             int unsigned off, int unsigned s1, int unsigned s2,
                             int unsigned s3);
        drain_and_settle();
        write_reg(CFG_LEVEL_COUNT, lv);
        write_reg(CFG_WRITE_BACK, wb);
        write_reg(CFG_POLICY, pol);
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_SET_FIRST, s1);
        write_reg(CFG_SET_SECOND, s2);
        write_reg(CFG_SET_THIRD, s3);
    endtask

    // mostly reused addresses so lines hit and age out, the rest fully random
    task automatic random_accesses(int count);
        logic [31:0] a;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 80)
                a = addr_pool[$urandom_range(23)] ^ $urandom_range(3);
            else
                a = $urandom;
            send_access($urandom_range(1), a);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, repeats and a conflicting set under reset settings
        send_access(0, 32'h0000_0000);
        send_access(1, 32'hFFFF_FFFF);
        send_access(0, 32'h0000_0000);
        send_access(1, 32'hFFFF_FFC0);
        for (int i = 0; i < 6; i++) send_access(i % 2, 32'h0001_0000 + i * 32'h1000);
        send_access(0, 32'h0001_0000);
        // write-back: dirty lines pushed down then out to memory
        configure(2, 1, POL_LRU, 6, 0, 0, 10);
        for (int i = 0; i < 12; i++) send_access(1, 32'h8000_0000 + i * 32'h40);
        send_access(0, 32'h8000_0000);

        // random phases over settings and idling modes
        configure(3, 1, POL_LRU, 6, 6, 8, 10);
        random_accesses(85);
        configure(3, 1, POL_FIFO, 0, 0, 1, 2);
        send_idle_pct = 68;
        random_accesses(85);
        configure(2, 1, POL_RANDOM, 4, 2, 3, 4);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        hold_go = 1;
        random_accesses(85);
        configure(1, 1, 3, 15, 15, 0, 10);
        send_idle_pct = 15;
        recv_stall_pct = 15;
        random_accesses(85);
        configure(0, 0, POL_RANDOM, 12, 1, 2, 3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_accesses(85);
        configure(3, 1, POL_RANDOM, 2, 1, 1, 1);
        send_idle_pct = 15;
        recv_stall_pct = 15;
        random_accesses(85);
        configure(3, 0, POL_LRU, 5, 10, 10, 10);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        random_accesses(85);

        drain_and_settle();
        $display("%0d accesses checked over nine settings; hits L1 %0d L2 %0d L3 %0d, misses %0d",
                 sb.checked, sb.hits[0], sb.hits[1], sb.hits[2], sb.hits[3]);
        $display("%0d field mismatches, %0d sent, %0d outstanding",
                 sb.mismatches, sent, sb.waiting.size());
        if (sb.mismatches == 0 && sb.waiting.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cmtm_pkg.sv
hdl/cmtm_tag_store.sv
hdl/cmtm_set_unit.sv
hdl/multilevel_cache_tag_model_unit.sv
sim/tb_multilevel_cache_tag_model_unit.sv
